>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/kmp_pkg.sv
package kmp_pkg;

  // Request codes.
  localparam logic [2:0] ReqLoadCmd  = 3'd0;
  localparam logic [2:0] ReqLoadTime = 3'd1;
  localparam logic [2:0] ReqPlay     = 3'd2;
  localparam logic [2:0] ReqStep     = 3'd3;
  localparam logic [2:0] ReqSeek     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CfgLoop    = 2'd0;
  localparam logic [1:0] CfgReverse = 2'd1;
  localparam logic [1:0] CfgPoses   = 2'd2;
  localparam logic [1:0] CfgMotors  = 2'd3;

  // Results per step never exceed this.
  localparam int unsigned ResultLimit = 32;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         pose_index;
    logic [4:0]         channel_index;
    logic               cmd_defined;
    logic signed [31:0] cmd_value;
    logic [23:0]        key_time;
    logic [31:0]        now_ms;
    logic signed [31:0] seek_time;
  } in_t;

  typedef struct packed {
    logic [4:0]         motor_id;
    logic signed [31:0] position;
    logic               position_set;
    logic               last;
    logic               motion_over;
    logic               playing_flag;
  } out_t;

  // Operands of the shared multiply-divide unit.
  typedef struct packed {
    logic        start;
    logic [30:0] a;
    logic [32:0] b;
    logic [24:0] d;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

endpackage

>>> hw/rtl/kmp_stream_if.sv
interface kmp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/kmp_muldiv.sv
module kmp_muldiv
  import kmp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  md_req_t    req_i,
  output md_status_t status_o,
  output logic [32:0] q_o
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_DIV  = 3'b100
  } phase_e;

  phase_e      phase_q;
  logic [6:0]  cnt_q;
  logic [63:0] mcand_q;
  logic [30:0] mplier_q;
  logic [63:0] acc_q;
  logic [63:0] num_q;
  logic [24:0] rem_q;
  logic [24:0] div_q;
  logic        done_q;

  logic [63:0] acc_nx;
  logic [25:0] rem_sh;
  logic        ge;

  // One 64-bit adder serves the shift-add product; one subtractor the restoring divide.
  assign acc_nx = acc_q + (mplier_q[0] ? mcand_q : 64'd0);
  assign rem_sh = {rem_q, num_q[63]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (req_i.start) begin
            phase_q <= PH_MUL;
            cnt_q   <= 7'd30;
          end
        end
        PH_MUL: begin
          if (cnt_q == 7'd0) begin
            phase_q <= PH_DIV;
            cnt_q   <= 7'd63;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        PH_DIV: begin
          if (cnt_q == 7'd0) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          mcand_q  <= {31'd0, req_i.b};
          mplier_q <= req_i.a;
          acc_q    <= '0;
          div_q    <= req_i.d;
        end
      end
      PH_MUL: begin
        acc_q    <= acc_nx;
        mcand_q  <= {mcand_q[62:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[30:1]};
        if (cnt_q == 7'd0) begin
          num_q <= acc_nx;
          rem_q <= '0;
        end
      end
      PH_DIV: begin
        rem_q <= ge ? 25'(rem_sh - {1'b0, div_q}) : rem_sh[24:0];
        num_q <= {num_q[62:0], ge};
      end
      default: ;
    endcase
  end

  assign status_o.busy = (phase_q != PH_IDLE);
  assign status_o.done = done_q;
  assign q_o           = num_q[32:0];

  `include "assert_macros.svh"
  `KMP_ASSERT_IMP(a_start_idle, clk_i, rst_ni, req_i.start, phase_q == PH_IDLE)
  `KMP_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q && phase_q == PH_IDLE)

endmodule

>>> hw/rtl/keyframe_motion_player.sv
// A step request works motor by motor: the keyframe scans read the table memories pose by
// pose, forward and then backward, and the shared multiply-divide (31 multiply steps, 64
// divide steps) interpolates between the keyframes found. One request is in work at a
// time; the next is taken once all results are registered. Reset clears control, timing
// state and configuration; the keyframe tables hold undefined data until loaded.
module keyframe_motion_player
  import kmp_pkg::*;
#(
  parameter int unsigned MAX_POSES  = 64,
  parameter int unsigned MAX_MOTORS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i,
  kmp_stream_if.sink   req_i,
  kmp_stream_if.source rsp_o
);

  localparam int unsigned PW  = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
  localparam int unsigned MW  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int unsigned PCW = $clog2(MAX_POSES + 1);
  localparam int unsigned VD  = MAX_POSES << MW;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DUR_RD   = 10'b0000000010,
    S_DUR_WAIT = 10'b0000000100,
    S_FWD_RD   = 10'b0000001000,
    S_FWD_CHK  = 10'b0000010000,
    S_BWD_RD   = 10'b0000100000,
    S_BWD_CHK  = 10'b0001000000,
    S_CALC     = 10'b0010000000,
    S_MULDIV   = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_e;

  state_e state_q;

  // Configuration.
  logic       loop_q, rev_q;
  logic [6:0] poses_q;
  logic [5:0] motors_q;

  // Timing state.
  logic signed [31:0] elapsed_q;
  logic [31:0]        prev_q;
  logic               playing_q;

  // Latched request and step context.
  in_t                item_q;
  logic signed [31:0] e_q, dur_q;
  logic               over_q;
  logic [PCW-1:0]     p_q;
  logic [5:0]         m_q;
  logic               bf_q, af_q;
  logic signed [31:0] bt_q, at_q, bv_q, av_q;
  logic               neg_q;
  logic signed [31:0] pos_q;
  logic               set_q;

  // Table memories, read data registered.
  logic [23:0] key_times [MAX_POSES];
  logic [32:0] key_vals [VD];
  logic [23:0] tdata_q;
  logic [32:0] vdata_q;
  logic [PW-1:0] rd_pose;

  out_t out_q;
  logic out_valid_q;

  md_req_t    md_req;
  md_status_t md_st;
  logic [32:0] md_q;

  logic [PCW-1:0]     n_w;
  logic [5:0]         mc_w;
  logic               accept;
  logic signed [31:0] t_w;
  logic signed [31:0] dur_w;
  logic               emit_go;
  logic [31:0]        delta_w;
  logic signed [31:0] new_e;
  logic               new_play;
  logic signed [32:0] dv_w;
  logic signed [32:0] qs_w;

  assign n_w = (32'(poses_q) > MAX_POSES) ? PCW'(MAX_POSES) : PCW'(poses_q);
  always_comb begin
    mc_w = motors_q;
    if (32'(mc_w) > MAX_MOTORS) mc_w = 6'(MAX_MOTORS);
    if (32'(mc_w) > ResultLimit) mc_w = 6'(ResultLimit);
  end

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign t_w         = $signed({8'd0, tdata_q});
  assign emit_go     = (state_q == S_EMIT) && (!out_valid_q || rsp_o.ready);

  // Duration as read from the last pose time; valid in S_DUR_WAIT.
  assign dur_w = (n_w == '0) ? 32'sd0 : t_w;

  // Read address follows the sequencer.
  always_comb begin
    case (state_q)
      S_DUR_RD: rd_pose = PW'(n_w - PCW'(1));
      S_BWD_RD: rd_pose = PW'(p_q - PCW'(1));
      default:  rd_pose = PW'(p_q);
    endcase
  end

  // Table writes from load requests, registered reads for the scans.
  always_ff @(posedge clk_i) begin
    if (accept && req_i.data.req_type == ReqLoadTime &&
        32'(req_i.data.pose_index) < MAX_POSES) begin
      key_times[PW'(req_i.data.pose_index)] <= req_i.data.key_time;
    end
    tdata_q <= key_times[rd_pose];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.data.req_type == ReqLoadCmd &&
        32'(req_i.data.pose_index) < MAX_POSES &&
        32'(req_i.data.channel_index) < MAX_MOTORS) begin
      key_vals[{PW'(req_i.data.pose_index), MW'(req_i.data.channel_index)}] <=
        {req_i.data.cmd_defined, req_i.data.cmd_value};
    end
    vdata_q <= key_vals[{rd_pose, MW'(m_q)}];
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b0;
      rev_q    <= 1'b0;
      poses_q  <= '0;
      motors_q <= 6'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLoop:    loop_q   <= cfg_data_i[0];
        CfgReverse: rev_q    <= cfg_data_i[0];
        CfgPoses:   poses_q  <= cfg_data_i;
        CfgMotors:  motors_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Time advance of a step, from the elapsed time at its start.
  always_comb begin
    delta_w  = item_q.now_ms - prev_q;
    new_e    = elapsed_q;
    new_play = playing_q;
    if (rev_q) begin
      if (elapsed_q <= 0) begin
        if (loop_q) begin
          new_e = dur_w;
        end else begin
          new_e    = '0;
          new_play = 1'b0;
        end
      end else begin
        new_e = elapsed_q - $signed(delta_w);
      end
    end else begin
      if (elapsed_q >= dur_w) begin
        if (loop_q) begin
          new_e = '0;
        end else begin
          new_e    = dur_w;
          new_play = 1'b0;
        end
      end else begin
        new_e = elapsed_q + $signed(delta_w);
      end
    end
  end

  assign dv_w = 33'(av_q) - 33'(bv_q);
  assign qs_w = neg_q ? -$signed(md_q) : $signed(md_q);

  // Shared multiply-divide request.
  always_comb begin
    md_req.start = (state_q == S_CALC) && af_q && bf_q && !(e_q > dur_q) && (at_q != bt_q);
    md_req.a     = 31'(e_q - bt_q);
    md_req.b     = dv_w[32] ? 33'(-dv_w) : 33'(dv_w);
    md_req.d     = 25'(at_q - bt_q);
  end

  kmp_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .status_o (md_st),
    .q_o      (md_q)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elapsed_q   <= '0;
      prev_q      <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      p_q         <= '0;
      m_q         <= '0;
    end else begin
      if (rsp_o.ready && !emit_go) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          p_q <= '0;
          if (accept) begin
            if (req_i.data.req_type == ReqPlay || req_i.data.req_type == ReqStep ||
                req_i.data.req_type == ReqSeek) begin
              state_q <= S_DUR_RD;
            end
          end
        end
        S_DUR_RD: state_q <= S_DUR_WAIT;
        S_DUR_WAIT: begin
          state_q <= S_IDLE;
          case (item_q.req_type)
            ReqPlay: begin
              prev_q    <= item_q.now_ms;
              playing_q <= 1'b1;
              if (rev_q && elapsed_q <= 0) elapsed_q <= dur_w;
              else if (!rev_q && elapsed_q >= dur_w) elapsed_q <= '0;
            end
            ReqSeek: begin
              if (item_q.seek_time < 0) elapsed_q <= '0;
              else if (item_q.seek_time > dur_w) elapsed_q <= dur_w;
              else elapsed_q <= item_q.seek_time;
            end
            default: begin
              prev_q    <= item_q.now_ms;
              elapsed_q <= new_e;
              playing_q <= new_play;
              m_q       <= '0;
              p_q       <= '0;
              if (mc_w != 6'd0) state_q <= (n_w == '0) ? S_CALC : S_FWD_RD;
            end
          endcase
        end
        S_FWD_RD: state_q <= S_FWD_CHK;
        S_FWD_CHK: begin
          if (t_w > e_q || p_q + PCW'(1) == n_w) begin
            p_q     <= n_w;
            state_q <= S_BWD_RD;
          end else begin
            p_q     <= p_q + PCW'(1);
            state_q <= S_FWD_RD;
          end
        end
        S_BWD_RD: state_q <= S_BWD_CHK;
        S_BWD_CHK: begin
          if (t_w < e_q || p_q == PCW'(1)) state_q <= S_CALC;
          else begin
            p_q     <= p_q - PCW'(1);
            state_q <= S_BWD_RD;
          end
        end
        S_CALC:   state_q <= md_req.start ? S_MULDIV : S_EMIT;
        S_MULDIV: if (md_st.done) state_q <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            p_q         <= '0;
            if (m_q + 6'd1 == mc_w) begin
              state_q <= S_IDLE;
            end else begin
              m_q     <= m_q + 6'd1;
              state_q <= (n_w == '0) ? S_CALC : S_FWD_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Step context and per-motor search results.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= req_i.data;
    case (state_q)
      S_DUR_WAIT: begin
        dur_q  <= dur_w;
        e_q    <= elapsed_q;
        bf_q   <= 1'b0;
        af_q   <= 1'b0;
        over_q <= !loop_q && (rev_q ? (new_e <= 0) : (new_e >= dur_w));
      end
      S_FWD_CHK: begin
        if (!(t_w > e_q) && vdata_q[32]) begin
          bf_q <= 1'b1;
          bt_q <= t_w;
          bv_q <= $signed(vdata_q[31:0]);
        end
      end
      S_BWD_CHK: begin
        if (!(t_w < e_q) && vdata_q[32]) begin
          af_q <= 1'b1;
          at_q <= t_w;
          av_q <= $signed(vdata_q[31:0]);
        end
      end
      S_CALC: begin
        neg_q <= dv_w[32];
        // A later keyframe alone commands a position only past the duration.
        set_q <= bf_q || (af_q && e_q > dur_q);
        if (af_q && e_q > dur_q) pos_q <= av_q;
        else if (bf_q) pos_q <= bv_q;
        else pos_q <= '0;
      end
      S_MULDIV: if (md_st.done) pos_q <= bv_q + qs_w[31:0];
      S_EMIT: begin
        if (emit_go) begin
          out_q.motor_id     <= m_q[4:0];
          out_q.position     <= pos_q;
          out_q.position_set <= set_q;
          out_q.last         <= (m_q + 6'd1 == mc_w);
          out_q.motion_over  <= over_q;
          out_q.playing_flag <= playing_q;
          bf_q               <= 1'b0;
          af_q               <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  `include "assert_macros.svh"
  `KMP_ASSERT_NXT(a_md_to_emit, clk_i, rst_ni, state_q == S_MULDIV && md_st.done,
                  state_q == S_EMIT)
  `KMP_ASSERT_NXT(a_last_idle, clk_i, rst_ni, emit_go && m_q + 6'd1 == mc_w,
                  state_q == S_IDLE && out_valid_q)
  `KMP_ASSERT_IMP(a_md_busy, clk_i, rst_ni, md_st.busy, state_q == S_MULDIV)

endmodule

>>> verif/kmp_checker.sv
`timescale 1ns / 1ps

module kmp_checker
  import kmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  in_t         req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  out_t        rsp_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int unsigned PoseSlots  = 64;
  localparam int unsigned MotorSlots = 32;

  // Mirror of the keyframe table and the playback state.
  logic [23:0] key_time_tbl [PoseSlots];
  logic [31:0] key_value_tbl [PoseSlots][MotorSlots];
  logic        key_set_tbl [PoseSlots][MotorSlots];
  logic [31:0] elapsed_ms;
  logic [31:0] last_now_ms;
  logic        playing;
  logic        loop_en;
  logic        reverse_en;
  logic [6:0]  pose_cnt;
  logic [5:0]  motor_cnt;

  out_t expected_positions[$];
  int unsigned mismatches;

  function automatic int unsigned active_poses();
    return (pose_cnt > PoseSlots) ? PoseSlots : int'(pose_cnt);
  endfunction

  function automatic int motion_length();
    int unsigned n;
    n = active_poses();
    return (n == 0) ? 0 : int'({8'd0, key_time_tbl[n-1]});
  endfunction

  // Applies one request to the mirror and queues the motor positions a step produces.
  task automatic apply_request(input in_t r);
    int dur;
    int e;
    int unsigned n;
    int unsigned mc;
    int bt, at, bv, av, t, pos;
    logic set;
    logic [31:0] delta;
    logic over;
    out_t res [MotorSlots];
    longint num, q;
    dur = motion_length();
    case (r.req_type)
      ReqLoadCmd: begin
        key_value_tbl[r.pose_index][r.channel_index] = r.cmd_value;
        key_set_tbl[r.pose_index][r.channel_index] = r.cmd_defined;
      end
      ReqLoadTime: begin
        key_time_tbl[r.pose_index] = r.key_time;
      end
      ReqPlay: begin
        e = int'(elapsed_ms);
        last_now_ms = r.now_ms;
        playing = 1'b1;
        if (reverse_en && e <= 0) elapsed_ms = dur;
        else if (!reverse_en && e >= dur) elapsed_ms = '0;
      end
      ReqSeek: begin
        if (r.seek_time < 0) elapsed_ms = '0;
        else if (int'(r.seek_time) > dur) elapsed_ms = dur;
        else elapsed_ms = r.seek_time;
      end
      ReqStep: begin
        n = active_poses();
        mc = (motor_cnt > MotorSlots) ? MotorSlots : int'(motor_cnt);
        e = int'(elapsed_ms);
        for (int unsigned m = 0; m < mc; m++) begin
          bt = -1; at = -1; bv = 0; av = 0; pos = 0; set = 1'b0;
          // Nearest defined keyframe at or before the elapsed time.
          for (int unsigned p = 0; p < n; p++) begin
            t = int'({8'd0, key_time_tbl[p]});
            if (t > e) break;
            if (key_set_tbl[p][m]) begin
              bt = t;
              bv = int'(key_value_tbl[p][m]);
            end
          end
          // Nearest defined keyframe at or after it, scanning from the end.
          for (int unsigned p = n; p > 0; p--) begin
            t = int'({8'd0, key_time_tbl[p-1]});
            if (t < e) break;
            if (key_set_tbl[p-1][m]) begin
              at = t;
              av = int'(key_value_tbl[p-1][m]);
            end
          end
          if (at != -1 && e > dur) begin
            set = 1'b1;
            pos = av;
          end else if (bt != -1 && at != -1) begin
            set = 1'b1;
            if (at == bt) begin
              pos = bv;
            end else begin
              num = (longint'(e) - bt) * (longint'(av) - bv);
              q = num / (longint'(at) - bt);
              pos = int'(longint'(bv) + q);
            end
          end else if (bt != -1) begin
            set = 1'b1;
            pos = bv;
          end
          res[m].motor_id = m[4:0];
          res[m].position = set ? pos : 0;
          res[m].position_set = set;
          res[m].last = (m + 1 == mc);
        end
        // Stop or wrap at the ends, else advance the elapsed time.
        delta = r.now_ms - last_now_ms;
        last_now_ms = r.now_ms;
        if (reverse_en) begin
          if (e <= 0) begin
            if (loop_en) elapsed_ms = dur;
            else begin
              elapsed_ms = '0;
              playing = 1'b0;
            end
          end else begin
            elapsed_ms = elapsed_ms - delta;
          end
        end else begin
          if (e >= dur) begin
            if (loop_en) elapsed_ms = '0;
            else begin
              elapsed_ms = dur;
              playing = 1'b0;
            end
          end else begin
            elapsed_ms = elapsed_ms + delta;
          end
        end
        e = int'(elapsed_ms);
        over = !loop_en && (reverse_en ? (e <= 0) : (e >= motion_length()));
        for (int unsigned m = 0; m < mc; m++) begin
          res[m].motion_over = over;
          res[m].playing_flag = playing;
          expected_positions.insert(expected_positions.size(), res[m]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      expected_positions.delete();
      elapsed_ms <= '0;
      last_now_ms <= '0;
      playing <= 1'b0;
      loop_en <= 1'b0;
      reverse_en <= 1'b0;
      pose_cnt <= '0;
      motor_cnt <= 6'd1;
      mismatches <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLoop: loop_en = cfg_data_i[0];
          CfgReverse: reverse_en = cfg_data_i[0];
          CfgPoses: pose_cnt = cfg_data_i;
          CfgMotors: motor_cnt = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) apply_request(req_data_i);
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_positions.size() == 0) begin
          if (mismatches < 10) $display("Unexpected motor result: %p", rsp_data_i);
          mismatches = mismatches + 1;
        end else begin
          want = expected_positions.pop_front();
          if (rsp_data_i !== want) begin
            if (mismatches < 10) begin
              $display("Motor result mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", rsp_data_i);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      pending_o <= expected_positions.size();
    end
  end

  assign fail_count_o = mismatches;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kmp_pkg::*;

  localparam int unsigned StallLimit = 60000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [6:0]  cfg_data;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  logic        quiet;
  logic        hold_request;
  logic [31:0] clock_ms;

  kmp_stream_if #(.T(in_t)) req_if ();
  kmp_stream_if #(.T(out_t)) rsp_if ();

  keyframe_motion_player dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  kmp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** keyframe_motion_player: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure unless quiet, plus one long hold-off on demand.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        rsp_if.ready <= 1'b0;
        repeat (500) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Offers one request and waits until the block takes it.
  task automatic send_request(input in_t r);
    if (!quiet && $urandom_range(0, 99) < 14) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req_if.data <= r;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic lp, input logic rv, input logic [6:0] poses,
                           input logic [5:0] motors);
    drain();
    write_reg(CfgLoop, {6'd0, lp});
    write_reg(CfgReverse, {6'd0, rv});
    write_reg(CfgPoses, poses);
    write_reg(CfgMotors, {1'b0, motors});
  endtask

  // Every field gets random bits; the caller then fixes what matters.
  function automatic in_t random_request(input logic [2:0] kind);
    logic [159:0] noise;
    in_t r;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(in_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  task automatic send_step(input logic [31:0] advance);
    in_t r;
    r = random_request(ReqStep);
    clock_ms = clock_ms + advance;
    r.now_ms = clock_ms;
    send_request(r);
  endtask

  task automatic send_play();
    in_t r;
    r = random_request(ReqPlay);
    r.now_ms = clock_ms;
    send_request(r);
  endtask

  task automatic send_seek(input logic [31:0] target);
    in_t r;
    r = random_request(ReqSeek);
    r.seek_time = target;
    send_request(r);
  endtask

  task automatic send_cmd(input logic [5:0] pose, input logic [4:0] ch, input logic def,
                          input logic [31:0] value);
    in_t r;
    r = random_request(ReqLoadCmd);
    r.pose_index = pose;
    r.channel_index = ch;
    r.cmd_defined = def;
    r.cmd_value = value;
    send_request(r);
  endtask

  task automatic send_time(input logic [5:0] pose, input logic [23:0] t);
    in_t r;
    r = random_request(ReqLoadTime);
    r.pose_index = pose;
    r.key_time = t;
    send_request(r);
  endtask

  // One playback phase: a play, then a random mix dominated by steps.
  task automatic run_phase(input logic lp, input logic rv, input logic [6:0] poses,
                           input logic [5:0] motors, input int unsigned count);
    int unsigned pick;
    configure(lp, rv, poses, motors);
    send_play();
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) send_step($urandom_range(0, 99) < 90 ? $urandom_range(0, 120) : $urandom);
      else if (pick < 68) send_seek($urandom_range(0, 1) ? $urandom_range(0, 2500) : $urandom);
      else if (pick < 76) send_play();
      else if (pick < 84) send_cmd(6'($urandom), 5'($urandom), 1'($urandom), $urandom);
      else if (pick < 92) send_time(6'($urandom),
                                    24'($urandom_range(0, 9) == 0 ? $urandom :
                                                                    $urandom_range(0, 2000)));
      else send_request(random_request(3'($urandom_range(5, 7))));
    end
  endtask

  initial begin
    logic [23:0] t;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    quiet = 1'b1;
    hold_request = 1'b0;
    quiet_cycles = 0;
    clock_ms = $urandom;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Times for eight poses, four motors on every pose and all motors on pose zero, so
    // no step below reads an entry that was never loaded.
    t = '0;
    for (int p = 0; p < 8; p++) begin
      t = t + 24'($urandom_range(0, 300));
      send_time(6'(p), t);
      for (int m = 0; m < 4; m++) send_cmd(6'(p), 5'(m), $urandom_range(0, 3) != 0, $urandom);
    end
    for (int m = 4; m < 32; m++) send_cmd(6'd0, 5'(m), $urandom_range(0, 3) != 0, $urandom);
    quiet = 1'b0;

    // Directed: value and time extremes, clock wrap, unknown requests, out-of-order times.
    configure(1'b0, 1'b0, 7'd8, 6'd3);
    send_cmd(6'd0, 5'd0, 1'b1, 32'h7FFF_FFFF);
    send_cmd(6'd7, 5'd0, 1'b1, 32'h8000_0000);
    send_cmd(6'd2, 5'd1, 1'b0, 32'h0);
    send_play();
    send_step(32'd0);
    send_seek(32'h8000_0000);
    send_step(32'd5);
    send_seek(32'h7FFF_FFFF);
    send_step(32'd1);
    send_step(32'd1);
    send_time(6'd3, 24'hFF_FFFF);
    send_seek(32'd50);
    send_step(32'd3);
    send_request(random_request(3'd5));
    send_request(random_request(3'd6));
    send_request(random_request(3'd7));
    clock_ms = 32'hFFFF_FFF0;
    send_play();
    send_step(32'd32);
    send_time(6'd7, 24'hFF_FFFF);
    send_seek(32'h00FF_FFFF);
    send_step(32'd7);

    // One pose and more motors than exist, then nothing at all.
    configure(1'b0, 1'b0, 7'd1, 6'd63);
    send_play();
    send_step(32'd20);
    send_step(32'd20);
    configure(1'b1, 1'b1, 7'd0, 6'd0);
    send_play();
    send_step(32'd10);
    send_step(32'd10);

    // Fill-up: results are held back while requests keep coming.
    configure(1'b0, 1'b0, 7'd8, 6'd4);
    send_play();
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++) send_step($urandom_range(0, 50));
    drain();

    // Mode sweep with a burst that never idles.
    quiet = 1'b1;
    run_phase(1'b1, 1'b0, 7'd6, 6'd2, 8);
    quiet = 1'b0;
    run_phase(1'b0, 1'b1, 7'd8, 6'd4, 8);
    run_phase(1'b1, 1'b1, 7'd4, 6'd1, 8);
    run_phase(1'($urandom), 1'($urandom), 7'($urandom_range(0, 8)),
              6'($urandom_range(0, 4)), 8);

    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** keyframe_motion_player: PASSED **");
    end else begin
      $display("** keyframe_motion_player: FAILED **");
    end
    $finish;
  end

endmodule

>>> keyframe_motion_player.f
+incdir+hw/rtl
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_stream_if.sv
hw/rtl/kmp_muldiv.sv
hw/rtl/keyframe_motion_player.sv
verif/kmp_checker.sv
verif/testbench.sv
